// File: rtl/core/luminance_histogram_unit_macros.svh
// ----------------------------------------------------------------------------
// Luminance histogram assertion macros
// Shared property templates for the luminance histogram checker.
// ----------------------------------------------------------------------------
`ifndef LUMINANCE_HISTOGRAM_UNIT_MACROS_SVH
`define LUMINANCE_HISTOGRAM_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define LHU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LHU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, always active
`define LHU_ASSERT_NORST(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lhu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Luminance histogram package
// Widths, constants and transfer types shared by the histogram modules.
// ----------------------------------------------------------------------------
package lhu_pkg;

  localparam int COUNT_BITS     = 21;
  localparam int OUT_COUNT_BITS = 21;
  localparam int NUM_BINS       = 256;
  localparam int BIN_BITS       = $clog2(NUM_BINS);
  localparam int PIX_BITS       = 8;
  localparam int SUM_BITS       = 15;
  localparam int RECIP_BITS     = 15;
  localparam int RECIP_SHIFT    = 21;
  localparam int PROD_BITS      = SUM_BITS + RECIP_BITS;
  localparam int FIFO_DEPTH     = 2;
  localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);
  localparam int MAX_IN_FLIGHT  = 6;
  localparam int PEND_BITS      = $clog2(MAX_IN_FLIGHT + 1);

  typedef logic [COUNT_BITS-1:0]     count_t;
  typedef logic [OUT_COUNT_BITS-1:0] out_count_t;
  typedef logic [BIN_BITS-1:0]       bin_t;
  typedef logic [PIX_BITS-1:0]       pix_t;
  typedef logic [SUM_BITS-1:0]       sum_t;
  typedef logic [PROD_BITS-1:0]      prod_t;
  typedef logic [PEND_BITS-1:0]      pend_t;

  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam count_t COUNT_MAX = '1;

  // floor(x / 100) = (x * ceil(2^21 / 100)) >> 21, exact for x <= 25500
  localparam sum_t W_RED     = sum_t'(30);
  localparam sum_t W_GREEN   = sum_t'(59);
  localparam sum_t W_BLUE    = sum_t'(11);
  localparam prod_t RECIP_100 = prod_t'(20972);

  typedef struct packed {
    logic command;
    pix_t red;
    pix_t green;
    pix_t blue;
    bin_t bin_index;
  } hist_in_t;

  typedef struct packed {
    bin_t       luminance;
    out_count_t bin_count;
  } hist_out_t;

  typedef struct packed {
    logic is_read;
    bin_t bin;
  } hist_op_t;

endpackage

// File: rtl/core/lhu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Luminance histogram front end
// Two-stage pipeline: weighted RGB sum, then divide by 100 into a bin index (reads pass bin_index).
// ----------------------------------------------------------------------------
module lhu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lhu_pkg::hist_in_t in_data,
  output logic              op_valid,
  input  logic              op_ready,
  output lhu_pkg::hist_op_t op
);

  logic              a_valid_r;
  logic              a_read_r;
  lhu_pkg::sum_t     a_sum_r;
  lhu_pkg::bin_t     a_idx_r;
  lhu_pkg::sum_t     a_sum_nxt;
  logic              a_ready;

  logic              b_valid_r;
  lhu_pkg::hist_op_t b_op_r;
  lhu_pkg::prod_t    b_prod;
  lhu_pkg::bin_t     b_bin_nxt;
  logic              b_ready;

  assign b_ready  = !b_valid_r || op_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;
  assign op_valid = b_valid_r;
  assign op       = b_op_r;

  always_comb begin
    a_sum_nxt = lhu_pkg::sum_t'(in_data.red)   * lhu_pkg::W_RED
              + lhu_pkg::sum_t'(in_data.green) * lhu_pkg::W_GREEN
              + lhu_pkg::sum_t'(in_data.blue)  * lhu_pkg::W_BLUE;
  end

  always_comb begin
    b_prod    = lhu_pkg::prod_t'(a_sum_r) * lhu_pkg::RECIP_100;
    b_bin_nxt = a_read_r ? a_idx_r : b_prod[lhu_pkg::RECIP_SHIFT +: lhu_pkg::BIN_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_read_r <= (in_data.command == lhu_pkg::CMD_READ);
      a_sum_r  <= a_sum_nxt;
      a_idx_r  <= in_data.bin_index;
    end
    if (b_ready && a_valid_r) begin
      b_op_r.is_read <= a_read_r;
      b_op_r.bin     <= b_bin_nxt;
    end
  end

endmodule

// File: rtl/core/lhu_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Luminance histogram operation queue
// Small register FIFO that decouples the front end from the count store.
// ----------------------------------------------------------------------------
module lhu_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lhu_pkg::hist_op_t in_op,
  output logic              out_valid,
  input  logic              out_ready,
  output lhu_pkg::hist_op_t out_op
);

  lhu_pkg::hist_op_t                     slot_r [lhu_pkg::FIFO_DEPTH];
  logic [lhu_pkg::FIFO_PTR_BITS-1:0]     wr_ptr_r;
  logic [lhu_pkg::FIFO_PTR_BITS-1:0]     rd_ptr_r;
  logic [lhu_pkg::FIFO_CNT_BITS-1:0]     cnt_r;
  logic [lhu_pkg::FIFO_CNT_BITS-1:0]     cnt_nxt;
  logic                                  push;
  logic                                  pop;

  assign in_ready  = (cnt_r != lhu_pkg::FIFO_CNT_BITS'(lhu_pkg::FIFO_DEPTH));
  assign out_valid = (cnt_r != '0);
  assign out_op    = slot_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r + lhu_pkg::FIFO_CNT_BITS'(push) - lhu_pkg::FIFO_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_op;
    end
  end

endmodule

// File: rtl/core/lhu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Luminance histogram back end
// Read-modify-write of the 256-bin count store and result output register.
// ----------------------------------------------------------------------------
module lhu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               op_valid,
  output logic               op_ready,
  input  lhu_pkg::hist_op_t  op,
  output logic               out_valid,
  input  logic               out_ready,
  output lhu_pkg::hist_out_t out_data
);

  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_t;

  state_t             state_r;
  state_t             state_nxt;
  logic               out_valid_r;
  lhu_pkg::hist_out_t out_data_r;

  lhu_pkg::count_t    mem [lhu_pkg::NUM_BINS];
  logic [lhu_pkg::NUM_BINS-1:0] vld_r;
  lhu_pkg::count_t    rd_cnt_r;
  logic               hit_r;
  lhu_pkg::hist_op_t  cur_r;

  lhu_pkg::count_t    old_cnt;
  lhu_pkg::count_t    wr_cnt;
  lhu_pkg::count_t    res_cnt;
  logic               pop;
  logic               out_free;
  logic               wr_en;

  assign op_ready  = (state_r == S_IDLE);
  assign pop       = op_valid && op_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign wr_en     = (state_r == S_CALC) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    old_cnt = hit_r ? rd_cnt_r : '0;
    if (cur_r.is_read) begin
      wr_cnt  = '0;
      res_cnt = old_cnt;
    end else begin
      wr_cnt  = (old_cnt == lhu_pkg::COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
      res_cnt = wr_cnt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (pop) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        out_valid_r          <= 1'b1;
        out_data_r.luminance <= cur_r.bin;
        out_data_r.bin_count <= lhu_pkg::out_count_t'(res_cnt);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // flag bins written since reset; others read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[cur_r.bin] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_cnt_r <= mem[op.bin];
      hit_r    <= vld_r[op.bin];
      cur_r    <= op;
    end
    if (wr_en) begin
      mem[cur_r.bin] <= wr_cnt;
    end
  end

endmodule

// File: rtl/core/luminance_histogram_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Luminance histogram unit
// 256-bin luminance histogram with saturating counts and read-and-clear.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data): command 0 takes an RGB pixel,
// computes floor((30R + 59G + 11B) / 100) and increments that bin; command 1
// returns bin_index's count and clears the bin.
// Output channel (out_valid/out_ready/out_data): one result per item, in
// order: the bin and its count after increment, or the bin and its count
// before clearing.
// Path: front-end sum and bin registers, queue, back-end read register,
// output register. The back end takes no new item until the last one's
// count read (S_IDLE) and write (S_CALC) of the memory are done.
// Reset: all bins read as zero right after reset through per-bin written
// flags; no clearing pass, items are taken at once.
// Stall: a result waits in the output register; up to six items are held
// in the pipeline, queue and output stage before in_ready drops.
// ----------------------------------------------------------------------------
module luminance_histogram_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lhu_pkg::hist_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lhu_pkg::hist_out_t out_data
);

  logic              fr_valid;
  logic              fr_ready;
  lhu_pkg::hist_op_t fr_op;
  logic              q_valid;
  logic              q_ready;
  lhu_pkg::hist_op_t q_op;

  lhu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .op_valid (fr_valid),
    .op_ready (fr_ready),
    .op       (fr_op)
  );

  lhu_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_op     (fr_op),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_op    (q_op)
  );

  lhu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (q_valid),
    .op_ready  (q_ready),
    .op        (q_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/lhu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Luminance histogram port checker
// Watches the top-level ports for result stability, occupancy and reset behavior.
// ----------------------------------------------------------------------------
`include "luminance_histogram_unit_macros.svh"

module lhu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input lhu_pkg::hist_out_t out_data
);

  lhu_pkg::pend_t pend_r;
  lhu_pkg::pend_t pend_nxt;
  logic           in_xfer;
  logic           out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r + lhu_pkg::pend_t'(in_xfer) - lhu_pkg::pend_t'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `LHU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  `LHU_ASSERT_SAME(a_out_has_item, clk, rst_n, out_valid, pend_r != '0, "result with no transfer outstanding")
  `LHU_ASSERT_SAME(a_pend_bound, clk, rst_n, 1'b1, pend_r <= lhu_pkg::pend_t'(lhu_pkg::MAX_IN_FLIGHT), "too many transfers outstanding")
  `LHU_ASSERT_NORST(a_reset_idle, clk, !rst_n, !out_valid, "result valid after reset")

endmodule

bind luminance_histogram_unit lhu_checker u_lhu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
